// ===== rtl/khq_pkg.sv =====
package khq_pkg;

  localparam int KEY_W   = 32;
  localparam int ARITY_W = 4;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

  // register index on the config port (paddr[2])
  localparam logic IDX_ARITY = 1'b0;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot;
    key_t              key;
  } token_t;

endpackage

// ===== rtl/khq_cell.sv =====
module khq_cell #(
  parameter int SLOT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  khq_pkg::token_t left,
  input  khq_pkg::key_t   rd_key,
  input  logic            rd_ok,
  output khq_pkg::token_t right
);

  logic take;

  // child SLOT arrives from memory in the same cycle as the token reaches this cell
  assign take = left.valid && rd_ok && (rd_key < left.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      right.valid <= 1'b0;
    end else begin
      right.valid <= left.valid;
    end
    if (take) begin
      right.found <= 1'b1;
      right.slot  <= khq_pkg::SLOT_W'(SLOT);
      right.key   <= rd_key;
    end else begin
      right.found <= left.found;
      right.slot  <= left.slot;
      right.key   <= left.key;
    end
  end

endmodule

// ===== rtl/k_ary_min_heap_queue.sv =====
// one operation at a time; busy stays high while the heap is being reordered
// insert: per parent compare a multiply, divide and compare step (parent via reciprocal multiply)
// extract: reads root and last entry, then per level computes and checks first child, k = arity;
// the k children stream one per cycle through the single memory read port into the cell chain
// done pulses one cycle with the result, the receiver cannot stall; count is valid with done
// synchronous reset empties the queue and sets arity to 2; the key memory is not cleared
module k_ary_min_heap_queue #(
  parameter int CAPACITY  = 1024,
  parameter int MAX_ARITY = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode,
  input  khq_pkg::key_t                      key_in,
  output logic                               done,
  output khq_pkg::key_t                      min_key,
  output logic [khq_pkg::STAT_W-1:0]         status,
  output logic [$clog2(CAPACITY+1)-1:0]      count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY+1);
  localparam int KW  = $clog2(MAX_ARITY+1);
  localparam int SLW = $clog2(MAX_ARITY);
  localparam int FW  = AW + KW;
  localparam int SH  = AW + KW;
  localparam int RW  = SH + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EX1     = 4'd1;
  localparam logic [3:0] S_EX2     = 4'd2;
  localparam logic [3:0] S_SD_MUL  = 4'd3;
  localparam logic [3:0] S_SD_CHK  = 4'd4;
  localparam logic [3:0] S_SD_RD   = 4'd5;
  localparam logic [3:0] S_SD_WAIT = 4'd6;
  localparam logic [3:0] S_SU_MUL  = 4'd7;
  localparam logic [3:0] S_SU_DIV  = 4'd8;
  localparam logic [3:0] S_SU_CMP  = 4'd9;

  logic [3:0]                    state;
  logic [khq_pkg::ARITY_W-1:0]   arity;
  logic [CW-1:0]                 entry_count;
  khq_pkg::key_t                 cur_key;
  khq_pkg::key_t                 min_r;
  logic                          is_ext;
  logic [AW-1:0]                 pos;
  logic [AW-1:0]                 par;
  logic [FW-1:0]                 first_r;
  logic [SLW-1:0]                j;
  logic [AW+RW-1:0]              prod;
  logic                          inj_valid;

  logic [KW-1:0]                 k_act;
  logic [SLW-1:0]                k_last;
  logic [RW-1:0]                 recip [MAX_ARITY+1];
  logic [AW-1:0]                 parent;
  logic [FW-1:0]                 child;

  khq_pkg::key_t                 heap_mem [CAPACITY];
  khq_pkg::key_t                 rd_key;
  logic                          rd_ok;
  logic [AW-1:0]                 ra;
  logic                          ra_ok;
  logic                          we;
  logic [AW-1:0]                 wa;
  khq_pkg::key_t                 wd;
  logic                          finish;

  khq_pkg::token_t               chain_in  [MAX_ARITY];
  khq_pkg::token_t               chain_out [MAX_ARITY];
  khq_pkg::token_t               tok_sel;

  // clamp the arity register into 2..MAX_ARITY
  always_comb begin
    if (arity < khq_pkg::ARITY_W'(2)) begin
      k_act = KW'(2);
    end else if (32'(arity) > MAX_ARITY) begin
      k_act = KW'(MAX_ARITY);
    end else begin
      k_act = KW'(arity);
    end
  end

  assign k_last = SLW'(k_act - KW'(1));

  // ceil(2^SH / k) gives the exact floor(x / k) for any x below 2^AW
  for (genvar g = 0; g <= MAX_ARITY; g++) begin : g_recip
    if (g < 2) begin : g_unused
      assign recip[g] = '0;
    end else begin : g_val
      localparam longint unsigned RV = ((longint'(1) << SH) + g - 1) / g;
      assign recip[g] = RW'(RV);
    end
  end

  assign parent = prod[SH +: AW];
  assign child  = first_r + FW'(j);

  // chain of compare cells, one per child slot
  assign chain_in[0] = '{valid: inj_valid, found: 1'b0, slot: '0, key: cur_key};
  for (genvar g = 0; g < MAX_ARITY; g++) begin : g_chain
    if (g > 0) begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    khq_cell #(
      .SLOT(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .left   (chain_in[g]),
      .rd_key (rd_key),
      .rd_ok  (rd_ok),
      .right  (chain_out[g])
    );
  end

  assign tok_sel = chain_out[k_last];

  always_comb begin
    ra     = '0;
    ra_ok  = 1'b0;
    we     = 1'b0;
    wa     = pos;
    wd     = cur_key;
    finish = 1'b0;
    case (state)
      S_IDLE: begin
        ra = '0;
      end
      S_EX1: begin
        ra = AW'(entry_count);
      end
      S_EX2: begin
        if (entry_count == '0) begin
          finish = 1'b1;
        end
      end
      S_SD_CHK: begin
        if (first_r >= FW'(entry_count)) begin
          we     = 1'b1;
          finish = 1'b1;
        end
      end
      S_SD_RD: begin
        ra    = child[AW-1:0];
        ra_ok = child < FW'(entry_count);
      end
      S_SD_WAIT: begin
        if (tok_sel.valid) begin
          we = 1'b1;
          if (tok_sel.found) begin
            wd = tok_sel.key;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_SU_MUL: begin
        if (pos == '0) begin
          we     = 1'b1;
          finish = 1'b1;
        end
      end
      S_SU_DIV: begin
        ra = parent;
      end
      S_SU_CMP: begin
        we = 1'b1;
        if (cur_key < rd_key) begin
          wd = rd_key;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[wa] <= wd;
    end
    rd_key <= heap_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      entry_count <= '0;
      arity       <= khq_pkg::ARITY_RESET;
      inj_valid   <= 1'b0;
      rd_ok       <= 1'b0;
    end else begin
      done      <= 1'b0;
      rd_ok     <= ra_ok;
      inj_valid <= (state == S_SD_RD) && (j == '0);
      if (psel && penable && pwrite && paddr[2] == khq_pkg::IDX_ARITY) begin
        arity <= pwdata[khq_pkg::ARITY_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (mode == khq_pkg::MODE_EXTRACT) begin
              if (entry_count == '0) begin
                done    <= 1'b1;
                status  <= khq_pkg::STATUS_EMPTY;
                min_key <= '0;
              end else begin
                entry_count <= entry_count - CW'(1);
                is_ext      <= 1'b1;
                state       <= S_EX1;
              end
            end else begin
              if (entry_count >= CW'(CAPACITY)) begin
                done    <= 1'b1;
                status  <= khq_pkg::STATUS_FULL;
                min_key <= '0;
              end else begin
                cur_key     <= key_in;
                pos         <= AW'(entry_count);
                entry_count <= entry_count + CW'(1);
                is_ext      <= 1'b0;
                state       <= S_SU_MUL;
              end
            end
          end
        end
        S_EX1: begin
          min_r <= rd_key;
          state <= S_EX2;
        end
        S_EX2: begin
          // last entry moves to the root
          cur_key <= rd_key;
          pos     <= '0;
          state   <= S_SD_MUL;
        end
        S_SD_MUL: begin
          first_r <= FW'(FW'(pos) * FW'(k_act) + FW'(1));
          state   <= S_SD_CHK;
        end
        S_SD_CHK: begin
          j     <= '0;
          state <= S_SD_RD;
        end
        S_SD_RD: begin
          j <= j + SLW'(1);
          if (j == k_last) begin
            state <= S_SD_WAIT;
          end
        end
        S_SD_WAIT: begin
          if (tok_sel.valid && tok_sel.found) begin
            pos   <= AW'(first_r + FW'(tok_sel.slot));
            state <= S_SD_MUL;
          end
        end
        S_SU_MUL: begin
          prod  <= (AW+RW)'((pos - AW'(1)) * recip[k_act]);
          state <= S_SU_DIV;
        end
        S_SU_DIV: begin
          par   <= parent;
          state <= S_SU_CMP;
        end
        S_SU_CMP: begin
          pos   <= par;
          state <= S_SU_MUL;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        done    <= 1'b1;
        status  <= khq_pkg::STATUS_OK;
        min_key <= is_ext ? min_r : '0;
        state   <= S_IDLE;
      end
    end
  end

  assign busy   = (state != S_IDLE);
  assign count  = entry_count;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == khq_pkg::IDX_ARITY) ? 32'(arity) : '0;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_on_finish: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("operation ended without a result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == khq_pkg::STATUS_EMPTY) |-> (min_key == '0 && count == '0))
    else $error("empty extract result malformed");

  // whenever the wait state repeats, the scan result has reached the selected cell
  a_chain_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_SD_WAIT && $past(state) == S_SD_WAIT) |-> tok_sel.valid)
    else $error("child scan result missing in wait state");
`endif

endmodule
